FILE: hw/rtl/afc_pkg.sv
// afc_pkg: shared widths, register indexes and the item type of the
// frustum cull pipeline. No dependencies.
`default_nettype none

package afc_pkg;

    localparam int NUM_PLANES = 6;
    localparam int COORD_W    = 18;
    localparam int NORM_W     = 10;
    localparam int DIST_W     = 18;
    localparam int PLANE_W    = 48;
    localparam int PROD_W     = NORM_W + COORD_W;
    localparam int DIST_SHIFT = 8;
    localparam int SUM_W      = 30;
    localparam int CFG_IDX_W  = 3;

    // packed plane register layout
    localparam int NX_LSB   = 0;
    localparam int NY_LSB   = 10;
    localparam int NZ_LSB   = 20;
    localparam int DIST_LSB = 30;

    // register indexes past the six planes
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING = 3'd7;

    // sector item as it travels down the chain of plane cells
    typedef struct packed {
        logic signed [COORD_W-1:0] x_min;
        logic signed [COORD_W-1:0] z_min;
        logic signed [COORD_W-1:0] x_max;
        logic signed [COORD_W-1:0] z_max;
        logic                      final_sector;
        logic                      visible;
    } t_item;

endpackage

`default_nettype wire

FILE: hw/rtl/afc_in_if.sv
// afc_in_if: input channel carrying one sector item with valid/ready.
// Depends on afc_pkg for the coordinate width.
`default_nettype none

interface afc_in_if
    import afc_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] box_x_min;
    logic signed [COORD_W-1:0] box_z_min;
    logic signed [COORD_W-1:0] box_x_max;
    logic signed [COORD_W-1:0] box_z_max;
    logic                      final_sector;

    modport source (
        output valid, box_x_min, box_z_min, box_x_max, box_z_max, final_sector,
        input  ready
    );

    modport sink (
        input  valid, box_x_min, box_z_min, box_x_max, box_z_max, final_sector,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/afc_out_if.sv
// afc_out_if: result channel carrying the visibility verdict with valid/ready.
// No dependencies.
`default_nettype none

interface afc_out_if;
    logic valid;
    logic ready;
    logic is_visible;
    logic final_flag;

    modport source (
        output valid, is_visible, final_flag,
        input  ready
    );

    modport sink (
        input  valid, is_visible, final_flag,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/aabb_frustum_cull.sv
// Sector box visibility against six frustum planes, one item per clock
// while the output is not stalled. Each sector item runs down a chain of six
// plane cells, one per plane, each two register stages deep (corner pick and
// multiply, then sum and sign test), so twelve register stages in all; the
// result is registered through all twelve before it shows on the output, and
// new items keep entering while earlier ones are still in the chain. A stalled
// output only holds the stages that are full, so empty stages keep taking
// items. The user must write plane, floor and ceiling registers only while
// the chain is empty; the block itself does not enforce this. After reset
// all planes are zero and every sector reads as culled. There is no clearing
// pass.
//
// Depends on afc_pkg, afc_in_if, afc_out_if and afc_plane_cell.
`default_nettype none

module aabb_frustum_cull
    import afc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    afc_in_if.sink                    i_in,
    afc_out_if.source                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [PLANE_W-1:0]   i_cfg_data
);

    logic [PLANE_W-1:0]        r_plane [NUM_PLANES];
    logic signed [COORD_W-1:0] r_floor, r_ceil;

    logic  c_valid [NUM_PLANES+1];
    logic  c_ready [NUM_PLANES+1];
    t_item c_item  [NUM_PLANES+1];

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) r_plane[p] <= '0;
            r_floor <= '0;
            r_ceil  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FLOOR:   r_floor <= i_cfg_data[COORD_W-1:0];
                REG_CEILING: r_ceil  <= i_cfg_data[COORD_W-1:0];
                default:     r_plane[i_cfg_idx] <= i_cfg_data;
            endcase
        end
    end

    // head of the chain: items enter marked visible
    always_comb begin
        c_item[0].x_min        = i_in.box_x_min;
        c_item[0].z_min        = i_in.box_z_min;
        c_item[0].x_max        = i_in.box_x_max;
        c_item[0].z_max        = i_in.box_z_max;
        c_item[0].final_sector = i_in.final_sector;
        c_item[0].visible      = 1'b1;
    end
    assign c_valid[0] = i_in.valid;
    assign i_in.ready = c_ready[0];

    // one cell per plane
    for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cell
        afc_plane_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_plane (r_plane[k]),
            .i_floor (r_floor),
            .i_ceil  (r_ceil),
            .i_valid (c_valid[k]),
            .i_item  (c_item[k]),
            .o_ready (c_ready[k]),
            .o_valid (c_valid[k+1]),
            .o_item  (c_item[k+1]),
            .i_ready (c_ready[k+1])
        );
    end

    // tail of the chain drives the result channel
    assign c_ready[NUM_PLANES] = o_out.ready;
    assign o_out.valid         = c_valid[NUM_PLANES];
    assign o_out.is_visible    = c_item[NUM_PLANES].visible;
    assign o_out.final_flag    = c_item[NUM_PLANES].final_sector;

endmodule

`default_nettype wire

FILE: hw/rtl/afc_plane_cell.sv
// afc_plane_cell: tests one item against one frustum plane in two stages
// and hands it on. Depends on afc_pkg.
`default_nettype none

module afc_plane_cell
    import afc_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [PLANE_W-1:0]        i_plane,
    input  wire logic signed [COORD_W-1:0] i_floor,
    input  wire logic signed [COORD_W-1:0] i_ceil,
    input  wire logic                      i_valid,
    input  wire t_item                     i_item,
    output logic                           o_ready,
    output logic                           o_valid,
    output t_item                          o_item,
    input  wire logic                      i_ready
);

    logic signed [NORM_W-1:0]  nx, ny, nz;
    logic signed [DIST_W-1:0]  plane_dist;
    logic signed [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
    logic signed [COORD_W-1:0] x_sel, y_sel, z_sel;
    logic signed [PROD_W-1:0]  n_px, n_py, n_pz;
    logic signed [SUM_W-1:0]   dist_sc, sum;
    logic                      a_ready, b_ready;
    t_item                     n_b_item;

    logic                      r_a_valid, r_b_valid;
    t_item                     r_a_item, r_b_item;
    logic signed [PROD_W-1:0]  r_px, r_py, r_pz;

    // plane fields
    assign nx         = i_plane[NX_LSB +: NORM_W];
    assign ny         = i_plane[NY_LSB +: NORM_W];
    assign nz         = i_plane[NZ_LSB +: NORM_W];
    assign plane_dist = i_plane[DIST_LSB +: DIST_W];

    // per axis, the corner coordinate that maximizes normal times coordinate
    always_comb begin
        x_lo = ($signed(i_item.x_min) < $signed(i_item.x_max)) ? i_item.x_min : i_item.x_max;
        x_hi = ($signed(i_item.x_min) < $signed(i_item.x_max)) ? i_item.x_max : i_item.x_min;
        z_lo = ($signed(i_item.z_min) < $signed(i_item.z_max)) ? i_item.z_min : i_item.z_max;
        z_hi = ($signed(i_item.z_min) < $signed(i_item.z_max)) ? i_item.z_max : i_item.z_min;
        y_lo = (i_floor < i_ceil) ? i_floor : i_ceil;
        y_hi = (i_floor < i_ceil) ? i_ceil : i_floor;
        x_sel = nx[NORM_W-1] ? x_lo : x_hi;
        y_sel = ny[NORM_W-1] ? y_lo : y_hi;
        z_sel = nz[NORM_W-1] ? z_lo : z_hi;
    end

    // stage one products
    assign n_px = nx * x_sel;
    assign n_py = ny * y_sel;
    assign n_pz = nz * z_sel;

    // stage two: best-corner sum, item stays visible if it is above zero
    assign dist_sc = {{(SUM_W - DIST_W - DIST_SHIFT){plane_dist[DIST_W-1]}}, plane_dist,
                      {DIST_SHIFT{1'b0}}};
    assign sum = SUM_W'(r_px) + SUM_W'(r_py) + SUM_W'(r_pz) + dist_sc;

    always_comb begin
        n_b_item         = r_a_item;
        n_b_item.visible = r_a_item.visible & (sum > 0);
    end

    // a stage advances when empty or when the next one takes its item
    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) r_a_valid <= i_valid;
            if (b_ready) r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_item <= i_item;
            r_px     <= n_px;
            r_py     <= n_py;
            r_pz     <= n_pz;
        end
        if (b_ready) r_b_item <= n_b_item;
    end

    assign o_ready = a_ready;
    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

endmodule

`default_nettype wire

FILE: hw/rtl/afc_checker.sv
// afc_checker: port-level assertions for aabb_frustum_cull and the bind
// that attaches them. Depends on the top level's port names only.
`default_nettype none

module afc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_is_visible,
    input wire logic i_out_final_flag,
    input wire logic i_cfg_we
);

    logic r_cfg_touched;

    // remembers any configuration write since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_touched <= 1'b0;
        end else if (i_cfg_we) begin
            r_cfg_touched <= 1'b1;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_is_visible) && $stable(i_out_final_flag))
        else $error("stalled result changed");

    // room at the tail means every stage can move, so input is taken
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input blocked although the output side can move");

    // chain is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result shown right after reset");

    // all-zero planes cull every sector
    a_zero_planes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cfg_touched && i_out_valid |-> !i_out_is_visible)
        else $error("sector visible with reset planes");

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_is_visible (o_out.is_visible),
    .i_out_final_flag (o_out.final_flag),
    .i_cfg_we         (i_cfg_we)
);

`default_nettype wire
